### rtl/rrtq_pkg.sv
`default_nettype none

package rrtq_pkg;

   // fixed field widths
   localparam int ID_W     = 8;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;

   // default list depth
   localparam int MAX_TASKS_DEF = 16;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [OP_W-1:0] OP_DEQUEUE  = 2'd1;
   localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd3;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCHED,
      S_SEARCH,
      S_SHIFT,
      S_REPLY
   } state_type;

endpackage

`default_nettype wire

### rtl/rrtq_ram.sv
`default_nettype none

module rrtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/round_robin_task_queue_core.sv
// Enqueue goes from idle straight to the reply state; schedule first reads the entry under the new cursor.
// Dequeue searches and then closes the gap (straight to reply on an empty list): the one-entry-per-cycle
// search and gap closing over the list memory read port visit each held entry once.
// One request at a time; the next is taken once the result is in the output register.
// Synchronous active-high reset empties the list, clears cursor and running task;
// list memory contents are not cleared.
`default_nettype none

module round_robin_task_queue_core #(
   parameter int MAX_TASKS = rrtq_pkg::MAX_TASKS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [rrtq_pkg::OP_W-1:0]         req_op,
   input  wire logic [rrtq_pkg::ID_W-1:0]         req_task_id,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic      [rrtq_pkg::STATUS_W-1:0]     rsp_status,
   output logic      [rrtq_pkg::ID_W-1:0]         rsp_chosen_id,
   output logic      [rrtq_pkg::ID_W-1:0]         rsp_previous_id,
   output logic                                   rsp_switch_needed,
   output logic      [$clog2(MAX_TASKS+1)-1:0]    rsp_entries_used
);

   import rrtq_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int CNT_W = $clog2(MAX_TASKS + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [IDX_W-1:0]    cursor_ff, cursor_in;
   logic [ID_W-1:0]     running_id_ff, running_id_in;
   logic                running_valid_ff, running_valid_in;
   logic [ID_W-1:0]     prior_id_ff, prior_id_in;
   logic [ID_W-1:0]     key_ff, key_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    hit_ff, hit_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_sched_ff, res_sched_in;
   logic                res_switch_ff, res_switch_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_chosen_ff, rsp_chosen_in;
   logic [ID_W-1:0]     rsp_previous_ff, rsp_previous_in;
   logic                rsp_switch_ff, rsp_switch_in;
   logic [CNT_W-1:0]    rsp_used_ff, rsp_used_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [ID_W-1:0]     ram_wdata;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ID_W-1:0]     ram_rdata;

   logic [SUM_W-1:0]    cursor_inc;
   logic [SUM_W-1:0]    idx_inc;
   logic [SUM_W-1:0]    idx_inc2;
   logic [IDX_W-1:0]    hit_sel;
   logic [IDX_W-1:0]    cursor_drop;
   logic                rsp_load;

   // list storage
   rrtq_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_TASKS)
   ) u_list (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // index adders for cursor and search index
   assign cursor_inc = SUM_W'(cursor_ff) + SUM_W'(1);
   assign idx_inc    = SUM_W'(idx_ff) + SUM_W'(1);
   assign idx_inc2   = SUM_W'(idx_ff) + SUM_W'(2);

   // cursor after a removal
   assign hit_sel = (state_ff == S_SEARCH) ? idx_ff : hit_ff;

   always_comb begin
      if (fill_ff == CNT_W'(1)) begin
         cursor_drop = '0;
      end else if (hit_sel == cursor_ff) begin
         cursor_drop = '0;
      end else if (hit_sel < cursor_ff) begin
         cursor_drop = cursor_ff - IDX_W'(1);
      end else begin
         cursor_drop = cursor_ff;
      end
   end

   assign rsp_load = (state_ff == S_REPLY) && (!rsp_valid_ff || rsp_ready);

   // sequencer next state and outputs
   always_comb begin
      state_in         = state_ff;
      fill_in          = fill_ff;
      cursor_in        = cursor_ff;
      running_id_in    = running_id_ff;
      running_valid_in = running_valid_ff;
      prior_id_in      = prior_id_ff;
      key_in           = key_ff;
      idx_in           = idx_ff;
      hit_in           = hit_ff;
      res_status_in    = res_status_ff;
      res_sched_in     = res_sched_ff;
      res_switch_in    = res_switch_ff;
      ram_we           = 1'b0;
      ram_waddr        = fill_ff[IDX_W-1:0];
      ram_wdata        = req_task_id;
      ram_raddr        = idx_ff;
      req_ready        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_status_in = STATUS_OK;
               res_sched_in  = 1'b0;
               res_switch_in = 1'b0;
               state_in      = S_REPLY;
               case (req_op)
                  OP_ENQUEUE: begin
                     if (fill_ff == FULL_CNT) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        ram_we  = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                        if (fill_ff == '0) begin
                           cursor_in = '0;
                        end
                     end
                  end
                  OP_DEQUEUE: begin
                     if (fill_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        key_in    = req_task_id;
                        idx_in    = '0;
                        ram_raddr = '0;
                        state_in  = S_SEARCH;
                     end
                  end
                  OP_SCHEDULE: begin
                     if (fill_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        if (cursor_inc >= SUM_W'(fill_ff)) begin
                           cursor_in = '0;
                        end else begin
                           cursor_in = cursor_inc[IDX_W-1:0];
                        end
                        ram_raddr = cursor_in;
                        state_in  = S_SCHED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // entry under the new cursor is on the read port
         S_SCHED: begin
            running_id_in    = ram_rdata;
            running_valid_in = 1'b1;
            res_sched_in     = 1'b1;
            if (running_valid_ff) begin
               prior_id_in   = running_id_ff;
               res_switch_in = 1'b1;
            end
            state_in = S_REPLY;
         end

         // one entry compared per cycle
         S_SEARCH: begin
            if (ram_rdata == key_ff) begin
               hit_in = idx_ff;
               if (idx_inc < SUM_W'(fill_ff)) begin
                  ram_raddr = idx_inc[IDX_W-1:0];
                  state_in  = S_SHIFT;
               end else begin
                  fill_in   = fill_ff - CNT_W'(1);
                  cursor_in = cursor_drop;
                  state_in  = S_REPLY;
               end
            end else if (idx_inc >= SUM_W'(fill_ff)) begin
               res_status_in = STATUS_NOTFOUND;
               state_in      = S_REPLY;
            end else begin
               idx_in    = idx_inc[IDX_W-1:0];
               ram_raddr = idx_inc[IDX_W-1:0];
            end
         end

         // move the next entry down one place per cycle
         S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            if (idx_inc2 < SUM_W'(fill_ff)) begin
               ram_raddr = idx_inc2[IDX_W-1:0];
               idx_in    = idx_inc[IDX_W-1:0];
            end else begin
               fill_in   = fill_ff - CNT_W'(1);
               cursor_in = cursor_drop;
               state_in  = S_REPLY;
            end
         end

         S_REPLY: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_chosen_in   = rsp_chosen_ff;
      rsp_previous_in = rsp_previous_ff;
      rsp_switch_in   = rsp_switch_ff;
      rsp_used_in     = rsp_used_ff;
      if (rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_status_in   = res_status_ff;
         rsp_chosen_in   = res_sched_ff ? running_id_ff : '0;
         rsp_previous_in = res_switch_ff ? prior_id_ff : '0;
         rsp_switch_in   = res_switch_ff;
         rsp_used_in     = fill_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         fill_ff          <= '0;
         cursor_ff        <= '0;
         running_id_ff    <= '0;
         running_valid_ff <= 1'b0;
         prior_id_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         fill_ff          <= fill_in;
         cursor_ff        <= cursor_in;
         running_id_ff    <= running_id_in;
         running_valid_ff <= running_valid_in;
         prior_id_ff      <= prior_id_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      key_ff          <= key_in;
      idx_ff          <= idx_in;
      hit_ff          <= hit_in;
      res_status_ff   <= res_status_in;
      res_sched_ff    <= res_sched_in;
      res_switch_ff   <= res_switch_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_chosen_ff   <= rsp_chosen_in;
      rsp_previous_ff <= rsp_previous_in;
      rsp_switch_ff   <= rsp_switch_in;
      rsp_used_ff     <= rsp_used_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_chosen_id     = rsp_chosen_ff;
   assign rsp_previous_id   = rsp_previous_ff;
   assign rsp_switch_needed = rsp_switch_ff;
   assign rsp_entries_used  = rsp_used_ff;

   // list never overfills
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count above list depth");

   // cursor stays inside the list, at the head when empty
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (SUM_W'(cursor_ff) < SUM_W'(fill_ff)) || (fill_ff == '0 && cursor_ff == '0))
      else $error("cursor outside the list");

   // fill count moves by at most one per cycle
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (fill_ff == $past(fill_ff) || fill_ff == $past(fill_ff) + CNT_W'(1)
                || fill_ff == $past(fill_ff) - CNT_W'(1)))
      else $error("fill count jumped");

   // search index stays below the fill count
   a_search_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH || state_ff == S_SHIFT) |-> SUM_W'(idx_ff) < SUM_W'(fill_ff))
      else $error("search index beyond list");

   // full status only reported on a full list
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status_ff == STATUS_FULL) |-> fill_ff == FULL_CNT)
      else $error("full status on a list with room");

endmodule

`default_nettype wire
